// ===== src/kspf_pkg.sv =====
package kspf_pkg;

	// Bitmap memory word geometry.
	localparam int WORD_BITS = 64;
	localparam int WORD_LSB  = 6;

	// Fixed field widths.
	localparam int MAP_INDEX_W = 20;
	localparam int MAP_SIZE_W  = 21;
	localparam int KMER_W      = 64;
	localparam int POS_W       = 32;
	localparam int FLAG_W      = 8;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 32;

	// The window starts this many positions later than a full read length back.
	localparam int READ_OVERLAP = 32;

	// Item kinds.
	localparam logic KIND_LOAD   = 1'b0;
	localparam logic KIND_FILTER = 1'b1;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_W-1:0] CFG_MAP_SIZE   = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_AMBIG_POS  = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_AMBIG_FLAG = 2'd2;

	// Inclusive bit window of one record, both ends inside the map.
	typedef struct packed {
		logic [MAP_INDEX_W-1:0] lo;
		logic [MAP_INDEX_W-1:0] hi;
	} window_t;

endpackage

// ===== src/kspf_bitmap_mem.sv =====
// Single-port word-wide bitmap store with a registered read.
module kspf_bitmap_mem #(
	parameter int WORDS  = 16384,
	parameter int ADDR_W = 14
) (
	input  logic                           clk,
	input  logic                           we,
	input  logic [ADDR_W-1:0]              addr,
	input  logic [kspf_pkg::WORD_BITS-1:0] wdata,
	output logic [kspf_pkg::WORD_BITS-1:0] rdata
);

	logic [kspf_pkg::WORD_BITS-1:0] mem [WORDS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

// ===== src/kspf_word_check.sv =====
// Masks one bitmap word to the part that lies inside the window and
// reports whether any SNP bit is left.
module kspf_word_check #(
	parameter int ADDR_W = 14
) (
	input  logic [ADDR_W-1:0]              addr,
	input  logic [kspf_pkg::WORD_BITS-1:0] word,
	input  kspf_pkg::window_t              win,
	output logic                           hit
);

	localparam logic [kspf_pkg::WORD_LSB-1:0] LAST_BIT =
		kspf_pkg::WORD_LSB'(kspf_pkg::WORD_BITS - 1);

	logic [ADDR_W-1:0]              lo_word;
	logic [ADDR_W-1:0]              hi_word;
	logic [kspf_pkg::WORD_LSB-1:0]  first_bit;
	logic [kspf_pkg::WORD_LSB-1:0]  last_bit;
	logic [kspf_pkg::WORD_BITS-1:0] mask;

	always_comb begin
		lo_word   = win.lo[ADDR_W+kspf_pkg::WORD_LSB-1:kspf_pkg::WORD_LSB];
		hi_word   = win.hi[ADDR_W+kspf_pkg::WORD_LSB-1:kspf_pkg::WORD_LSB];
		first_bit = (addr == lo_word) ? win.lo[kspf_pkg::WORD_LSB-1:0] : '0;
		last_bit  = (addr == hi_word) ? win.hi[kspf_pkg::WORD_LSB-1:0] : LAST_BIT;
		mask      = ({kspf_pkg::WORD_BITS{1'b1}} << first_bit) &
			({kspf_pkg::WORD_BITS{1'b1}} >> (LAST_BIT - last_bit));
		hit       = |(word & mask);
	end

endmodule

// ===== src/kmer_snp_proximity_filter.sv =====
// Load item: the word is read at accept, then written back with the new bit.
// Filter item: window set-up, scan of the W bitmap words it spans (up to 4 for a
// read length of 100), settle, decide; an ambiguous or outside-the-map record skips
// the scan. A kept item shows the cycle after the decision; the receiver cannot stall.
// Reset (arst_n low, asynchronous) clears control, counter and configuration;
// the bitmap is not cleared and holds nothing valid until loaded.
module kmer_snp_proximity_filter #(
	parameter longint unsigned MAP_DEPTH   = 64'd1048576,
	parameter int              READ_LENGTH = 100
) (
	input  logic                             clk,
	input  logic                             arst_n,

	// Item channel.
	input  logic                             start,
	output logic                             busy,
	input  logic                             kind,
	input  logic [kspf_pkg::MAP_INDEX_W-1:0] map_index,
	input  logic                             snp_bit,
	input  logic [kspf_pkg::KMER_W-1:0]      kmer,
	input  logic [kspf_pkg::POS_W-1:0]       position,
	input  logic [kspf_pkg::FLAG_W-1:0]      kmer_flag,

	// Configuration write channel.
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [kspf_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [kspf_pkg::CFG_DATA_W-1:0]  cfg_data,

	// Result channel: one strobed cycle per kept record.
	output logic                             result_valid,
	output logic [kspf_pkg::KMER_W-1:0]      kept_kmer,
	output logic [kspf_pkg::POS_W-1:0]       kept_position,
	output logic [kspf_pkg::FLAG_W-1:0]      kept_flag,
	output logic [kspf_pkg::POS_W-1:0]       removed_total
);

	// Only positions a load item can address are ever stored, so the memory
	// is sized to the smaller of the map depth and the index range.
	localparam longint unsigned INDEX_SPAN = 64'd1 << kspf_pkg::MAP_INDEX_W;
	localparam longint unsigned MAP_BITS   = (MAP_DEPTH < INDEX_SPAN) ? MAP_DEPTH : INDEX_SPAN;
	localparam int WORDS  = int'((MAP_BITS + kspf_pkg::WORD_BITS - 1) / kspf_pkg::WORD_BITS);
	localparam int ADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1;

	localparam logic [kspf_pkg::MAP_SIZE_W-1:0] MAP_BITS_W = kspf_pkg::MAP_SIZE_W'(MAP_BITS);
	localparam logic [kspf_pkg::MAP_SIZE_W-1:0] BACK_OFF   =
		kspf_pkg::MAP_SIZE_W'(READ_LENGTH - kspf_pkg::READ_OVERLAP);
	localparam logic [kspf_pkg::MAP_SIZE_W-1:0] AHEAD_OFF  =
		kspf_pkg::MAP_SIZE_W'(READ_LENGTH - 1);
	localparam logic [kspf_pkg::POS_W-1:0]      COUNT_MAX  = '1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD_WR,
		ST_WINDOW,
		ST_SCAN,
		ST_SETTLE,
		ST_DECIDE
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [kspf_pkg::MAP_SIZE_W-1:0] map_size_q;
	logic [kspf_pkg::POS_W-1:0]      ambig_pos_q;
	logic [kspf_pkg::FLAG_W-1:0]     ambig_code_q;

	// Record held while it is examined.
	logic [kspf_pkg::KMER_W-1:0]     kmer_q;
	logic [kspf_pkg::POS_W-1:0]      pos_q;
	logic [kspf_pkg::FLAG_W-1:0]     flag_q;
	logic                            ambig_q;

	// Pending load.
	logic [ADDR_W-1:0]               load_addr_q;
	logic [kspf_pkg::WORD_LSB-1:0]   load_bit_q;
	logic                            load_val_q;

	// Window scan.
	kspf_pkg::window_t               win_q;
	kspf_pkg::window_t               win_next;
	logic [ADDR_W-1:0]               rd_addr_q;
	logic                            hit_q;
	logic                            chk_valid_s1;
	logic [ADDR_W-1:0]               chk_addr_s1;
	logic                            chk_hit;
	logic [ADDR_W-1:0]               hi_word;

	logic [kspf_pkg::POS_W-1:0]      removed_q;

	// Memory port.
	logic                            mem_we;
	logic [ADDR_W-1:0]               mem_addr;
	logic [kspf_pkg::WORD_BITS-1:0]  mem_wdata;
	logic [kspf_pkg::WORD_BITS-1:0]  mem_rdata;

	// Window arithmetic.
	logic [kspf_pkg::MAP_SIZE_W-1:0] size_eff;
	logic [kspf_pkg::MAP_SIZE_W-1:0] size_m1;
	logic [kspf_pkg::MAP_SIZE_W-1:0] pos_low;
	logic [kspf_pkg::MAP_SIZE_W-1:0] lo_calc;
	logic [kspf_pkg::MAP_SIZE_W-1:0] hi_raw;
	logic [kspf_pkg::MAP_SIZE_W-1:0] hi_calc;
	logic                            in_map;

	logic                            accept;
	logic                            load_in_range;
	logic                            keep;

	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;

	// A load outside the map depth is dropped without touching memory.
	assign load_in_range = ({1'b0, map_index} < MAP_BITS_W);

	// The effective map never exceeds what the memory holds. A position at
	// or past it gives an empty window; otherwise both ends are clamped.
	always_comb begin
		size_eff = (map_size_q > MAP_BITS_W) ? MAP_BITS_W : map_size_q;
		size_m1  = size_eff - kspf_pkg::MAP_SIZE_W'(1);
		in_map   = (pos_q < {{(kspf_pkg::POS_W-kspf_pkg::MAP_SIZE_W){1'b0}}, size_eff});
		pos_low  = pos_q[kspf_pkg::MAP_SIZE_W-1:0];
		lo_calc  = (pos_low > BACK_OFF) ? (pos_low - BACK_OFF) : '0;
		hi_raw   = pos_low + AHEAD_OFF;
		hi_calc  = (hi_raw > size_m1) ? size_m1 : hi_raw;
		win_next.lo = lo_calc[kspf_pkg::MAP_INDEX_W-1:0];
		win_next.hi = hi_calc[kspf_pkg::MAP_INDEX_W-1:0];
	end

	assign hi_word = win_q.hi[ADDR_W+kspf_pkg::WORD_LSB-1:kspf_pkg::WORD_LSB];
	assign keep    = ambig_q || hit_q;

	// The memory sees the load address at accept, the write-back in the
	// cycle after, and the running scan address otherwise.
	always_comb begin
		mem_we    = 1'b0;
		mem_addr  = rd_addr_q;
		mem_wdata = mem_rdata;
		case (state_q)
			ST_IDLE: begin
				mem_addr = map_index[ADDR_W+kspf_pkg::WORD_LSB-1:kspf_pkg::WORD_LSB];
			end
			ST_LOAD_WR: begin
				mem_we               = 1'b1;
				mem_addr             = load_addr_q;
				mem_wdata[load_bit_q] = load_val_q;
			end
			default: begin
				mem_addr = rd_addr_q;
			end
		endcase
	end

	kspf_bitmap_mem #(
		.WORDS  (WORDS),
		.ADDR_W (ADDR_W)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	// Each word read in the scan is checked in the cycle its data returns.
	kspf_word_check #(
		.ADDR_W (ADDR_W)
	) u_check (
		.addr (chk_addr_s1),
		.word (mem_rdata),
		.win  (win_q),
		.hit  (chk_hit)
	);

	// The user must write configuration only while the block is idle; the block does not enforce it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_size_q   <= '0;
			ambig_pos_q  <= '1;
			ambig_code_q <= kspf_pkg::FLAG_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				kspf_pkg::CFG_MAP_SIZE:   map_size_q   <= cfg_data[kspf_pkg::MAP_SIZE_W-1:0];
				kspf_pkg::CFG_AMBIG_POS:  ambig_pos_q  <= cfg_data;
				kspf_pkg::CFG_AMBIG_FLAG: ambig_code_q <= cfg_data[kspf_pkg::FLAG_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Sequencer: state, counter, scan flags and the result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			removed_q    <= '0;
			hit_q        <= 1'b0;
			chk_valid_s1 <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			result_valid <= 1'b0;
			chk_valid_s1 <= (state_q == ST_SCAN);
			if (chk_valid_s1 && chk_hit) begin
				hit_q <= 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (kind == kspf_pkg::KIND_FILTER) begin
							state_q <= ST_WINDOW;
						end else if (load_in_range) begin
							state_q <= ST_LOAD_WR;
						end
					end
				end
				ST_LOAD_WR: begin
					state_q <= ST_IDLE;
				end
				ST_WINDOW: begin
					hit_q   <= 1'b0;
					state_q <= (ambig_q || !in_map) ? ST_DECIDE : ST_SCAN;
				end
				ST_SCAN: begin
					if (rd_addr_q == hi_word) begin
						state_q <= ST_SETTLE;
					end
				end
				ST_SETTLE: begin
					state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					result_valid <= keep;
					if (!keep && removed_q != COUNT_MAX) begin
						removed_q <= removed_q + kspf_pkg::POS_W'(1);
					end
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers; they carry no reset.
	always_ff @(posedge clk) begin
		if (accept) begin
			kmer_q      <= kmer;
			pos_q       <= position;
			flag_q      <= kmer_flag;
			ambig_q     <= (position == ambig_pos_q) || (kmer_flag == ambig_code_q);
			load_addr_q <= map_index[ADDR_W+kspf_pkg::WORD_LSB-1:kspf_pkg::WORD_LSB];
			load_bit_q  <= map_index[kspf_pkg::WORD_LSB-1:0];
			load_val_q  <= snp_bit;
		end
		if (state_q == ST_WINDOW) begin
			win_q     <= win_next;
			rd_addr_q <= win_next.lo[ADDR_W+kspf_pkg::WORD_LSB-1:kspf_pkg::WORD_LSB];
		end else if (state_q == ST_SCAN) begin
			rd_addr_q <= rd_addr_q + ADDR_W'(1);
		end
		chk_addr_s1 <= rd_addr_q;
		if (state_q == ST_DECIDE) begin
			kept_kmer     <= kmer_q;
			kept_position <= pos_q;
			kept_flag     <= flag_q;
			removed_total <= removed_q;
		end
	end

endmodule
